>>> hdl/uuencode_line_encoder_core_macros.svh
// assertion macros for the uuencode line encoder checker
`ifndef UUENCODE_LINE_ENCODER_CORE_MACROS_SVH
`define UUENCODE_LINE_ENCODER_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define UUENC_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define UUENC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> hdl/uuenc_pkg.sv
package uuenc_pkg;

  localparam int LINE_BYTES  = 45;
  localparam int STORE_DEPTH = 45;
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

  localparam logic [6:0] CH_NL    = 7'd10;
  localparam logic [6:0] CH_ZERO  = 7'd96;
  localparam logic [6:0] CH_SPACE = 7'd32;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LEN,
    S_FETCH,
    S_CAPT,
    S_CHAR,
    S_NL,
    S_TZ,
    S_TN
  } state_t;

  typedef enum logic [1:0] {
    CK_LEN,
    CK_DATA,
    CK_NL,
    CK_TERM
  } char_kind_t;

  typedef struct packed {
    logic             wr_en;
    logic [CNT_W-1:0] wr_addr;
    logic [7:0]       wr_data;
    logic             rd_en;
    logic [CNT_W-1:0] rd_addr;
  } mem_req_t;

  typedef struct packed {
    logic             valid;
    char_kind_t       kind;
    logic [1:0]       slot;
    logic [5:0]       len;
    logic [7:0]       b0;
    logic [7:0]       b1;
    logic [7:0]       b2;
    logic             run_last;
    logic             done;
  } emit_req_t;

  // 6-bit value to printable character, zero goes to backquote
  function automatic logic [6:0] enc6(input logic [5:0] v);
    logic [6:0] ch;
    if (v == 6'd0) begin
      ch = CH_ZERO;
    end else begin
      ch = {1'b0, v} + CH_SPACE;
    end
    return ch;
  endfunction

endpackage

>>> hdl/uuenc_if.sv
interface uuenc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_message;

  modport source (output valid, data_byte, byte_present, end_of_message, input ready);
  modport sink (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface uuenc_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       run_last;
  logic       message_done;

  modport source (output valid, out_char, run_last, message_done, input ready);
  modport sink (input valid, out_char, run_last, message_done, output ready);
endinterface

>>> hdl/uuenc_line_mem.sv
module uuenc_line_mem import uuenc_pkg::*; (
  input  logic       clk,
  input  mem_req_t   req,
  output logic [7:0] rd_data
);

  logic [7:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

>>> hdl/uuenc_char_unit.sv
module uuenc_char_unit import uuenc_pkg::*; (
  input  emit_req_t  req,
  output logic [6:0] ch
);

  logic [5:0] v;

  always_comb begin
    unique case (req.slot)
      2'd0:    v = req.b0[7:2];
      2'd1:    v = {req.b0[1:0], req.b1[7:4]};
      2'd2:    v = {req.b1[3:0], req.b2[7:6]};
      2'd3:    v = req.b2[5:0];
      default: v = 6'd0;
    endcase
  end

  always_comb begin
    unique case (req.kind)
      CK_LEN:  ch = enc6(req.len);
      CK_DATA: ch = enc6(v);
      CK_NL:   ch = CH_NL;
      CK_TERM: ch = CH_ZERO;
      default: ch = CH_NL;
    endcase
  end

endmodule

>>> hdl/uuenc_seq.sv
module uuenc_seq import uuenc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [7:0] in_data,
  input  logic       in_present,
  input  logic       in_eom,
  output logic       in_ready,
  output mem_req_t   mem_req,
  input  logic [7:0] rd_data,
  output emit_req_t  emit,
  input  logic       emit_ok
);

  state_t           state, state_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] gidx;
  logic [1:0]       sub;
  logic [1:0]       slot;
  logic             eom_pend;
  logic [7:0]       grp [3];

  logic             accept;
  logic             wr_ok;
  logic [CNT_W-1:0] cnt_acc;
  logic [CNT_W-1:0] byte_pos;
  logic [CNT_W-1:0] gidx_step;
  logic             full_hit;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign wr_ok     = in_present && (count < CNT_W'(STORE_DEPTH));
  assign cnt_acc   = wr_ok ? count + CNT_W'(1) : count;
  assign full_hit  = in_present && (cnt_acc >= CNT_W'(LINE_BYTES));
  assign byte_pos  = gidx + CNT_W'(sub);
  assign gidx_step = gidx + CNT_W'(3);

  always_comb begin
    mem_req.wr_en   = accept && wr_ok;
    mem_req.wr_addr = count;
    mem_req.wr_data = in_data;
    mem_req.rd_en   = (state == S_FETCH);
    mem_req.rd_addr = byte_pos;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (full_hit) begin
            state_next = S_LEN;
          end else if (in_eom) begin
            state_next = (cnt_acc != '0) ? S_LEN : S_TZ;
          end
        end
      end
      S_LEN:   if (emit_ok) state_next = S_FETCH;
      S_FETCH: state_next = S_CAPT;
      S_CAPT:  state_next = (sub == 2'd2) ? S_CHAR : S_FETCH;
      S_CHAR: begin
        if (emit_ok && slot == 2'd3) begin
          state_next = (gidx_step < count) ? S_FETCH : S_NL;
        end
      end
      S_NL:    if (emit_ok) state_next = eom_pend ? S_TZ : S_IDLE;
      S_TZ:    if (emit_ok) state_next = S_TN;
      S_TN:    if (emit_ok) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // character request
  always_comb begin
    emit.valid    = 1'b0;
    emit.kind     = CK_DATA;
    emit.slot     = slot;
    emit.len      = count;
    emit.b0       = grp[0];
    emit.b1       = grp[1];
    emit.b2       = grp[2];
    emit.run_last = 1'b0;
    emit.done     = 1'b0;
    unique case (state)
      S_LEN: begin
        emit.valid = 1'b1;
        emit.kind  = CK_LEN;
      end
      S_CHAR: begin
        emit.valid = 1'b1;
        emit.kind  = CK_DATA;
      end
      S_NL: begin
        emit.valid    = 1'b1;
        emit.kind     = CK_NL;
        emit.run_last = !eom_pend;
      end
      S_TZ: begin
        emit.valid = 1'b1;
        emit.kind  = CK_TERM;
      end
      S_TN: begin
        emit.valid    = 1'b1;
        emit.kind     = CK_NL;
        emit.run_last = 1'b1;
        emit.done     = 1'b1;
      end
      S_IDLE, S_FETCH, S_CAPT: emit.valid = 1'b0;
      default: emit.valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      gidx     <= '0;
      sub      <= '0;
      slot     <= '0;
      eom_pend <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        count    <= cnt_acc;
        eom_pend <= in_eom;
        gidx     <= '0;
        sub      <= '0;
        slot     <= '0;
      end
      if (state == S_CAPT) begin
        sub <= (sub == 2'd2) ? 2'd0 : sub + 2'd1;
      end
      if (state == S_CHAR && emit_ok) begin
        slot <= slot + 2'd1;
        if (slot == 2'd3) begin
          gidx <= gidx_step;
        end
      end
      if (state == S_NL && emit_ok) begin
        count <= '0;
      end
    end
  end

  // group bytes, padded with zero past the line end
  always_ff @(posedge clk) begin
    if (state == S_CAPT) begin
      grp[sub] <= (byte_pos < count) ? rd_data : 8'd0;
    end
  end

endmodule

>>> hdl/uuencode_line_encoder_core.sv
// uuencode line encoder
// in_ch takes one word per message byte: data_byte with byte_present set,
// and end_of_message on the word that closes the message (a bare end marker
// has byte_present clear). out_ch gives one ASCII character per word.
// bytes collect in a 45-entry line store; the word that fills the line, or
// an end of message with bytes pending, starts a line: length character,
// four characters per three-byte group, newline. end of message then adds
// the terminator line, backquote and newline, with message_done on the
// newline. run_last marks the last character caused by an input word.
// a word that causes no line leaves the encoder idle. each group of a line
// reads its three bytes one at a time through the registered read port of
// the store (a fetch state, then a capture state, per byte), then the single
// character unit builds one character per cycle while the receiver does not
// stall. in_ch is not ready while a line is being sent. out_ch is fed from
// one output register; when the receiver stalls the register holds and the
// sequencer waits on it. reset (rst, synchronous) empties the line and
// returns to idle; the store contents are not cleared, and bytes read past
// the line end are replaced by zero padding.
module uuencode_line_encoder_core import uuenc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  uuenc_in_if.sink    in_ch,
  uuenc_out_if.source out_ch
);

  mem_req_t   mem_req;
  logic [7:0] rd_data;
  emit_req_t  emit;
  logic       emit_ok;
  logic [6:0] ch;

  logic       out_valid;
  logic [6:0] out_char;
  logic       run_last;
  logic       message_done;

  assign emit_ok = !out_valid || out_ch.ready;

  uuenc_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_ch.valid),
    .in_data    (in_ch.data_byte),
    .in_present (in_ch.byte_present),
    .in_eom     (in_ch.end_of_message),
    .in_ready   (in_ch.ready),
    .mem_req    (mem_req),
    .rd_data    (rd_data),
    .emit       (emit),
    .emit_ok    (emit_ok)
  );

  uuenc_line_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  uuenc_char_unit u_char (
    .req (emit),
    .ch  (ch)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_ok) begin
      out_valid <= emit.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_ok && emit.valid) begin
      out_char     <= ch;
      run_last     <= emit.run_last;
      message_done <= emit.done;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.out_char     = out_char;
  assign out_ch.run_last     = run_last;
  assign out_ch.message_done = message_done;

endmodule

>>> hdl/uuenc_checker.sv
`include "uuencode_line_encoder_core_macros.svh"

module uuenc_checker import uuenc_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] out_char,
  input logic       run_last,
  input logic       message_done
);

  `UUENC_ASSERT_NOW(a_done_is_last, out_valid && message_done, run_last, "message_done without run_last")
  `UUENC_ASSERT_NOW(a_done_on_nl, out_valid && message_done, out_char == CH_NL, "message_done off newline")
  `UUENC_ASSERT_NOW(a_last_on_nl, out_valid && run_last, out_char == CH_NL, "run_last off newline")
  `UUENC_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(out_char), "stalled word changed")

endmodule

bind uuencode_line_encoder_core uuenc_checker u_chk (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_char     (out_ch.out_char),
  .run_last     (out_ch.run_last),
  .message_done (out_ch.message_done)
);

>>> dv/tb_uuencode_line_encoder_core.sv
module tb_uuencode_line_encoder_core;
  import uuenc_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 200;
  localparam int PHASE_WORDS  = 40;

  typedef struct {
    logic [6:0] ch;
    logic       last;
    logic       done;
  } uu_char_t;

  logic clk;
  logic rst;

  uuenc_in_if  in_ch();
  uuenc_out_if out_ch();

  uuencode_line_encoder_core dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  uu_char_t    expected_chars[$];
  logic [7:0]  line_bytes[LINE_BYTES];
  int unsigned line_fill;
  int unsigned sender_idle_pct;
  int unsigned sink_stall_pct;
  int unsigned error_count;
  int unsigned cycle_count;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [6:0] printable(input logic [5:0] v);
    logic [6:0] ch;
    if (v == 6'd0) begin
      ch = CH_ZERO;
    end else begin
      ch = {1'b0, v} + CH_SPACE;
    end
    return ch;
  endfunction

  function automatic void push_char(input logic [6:0] ch, input logic done);
    uu_char_t c;
    c.ch   = ch;
    c.last = 1'b0;
    c.done = done;
    expected_chars.push_back(c);
  endfunction

  // length char, four chars per group (zero padded), newline
  function automatic void flush_line();
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    int unsigned i;
    push_char(printable(6'(line_fill)), 1'b0);
    for (i = 0; i < line_fill; i += 3) begin
      b0 = line_bytes[i];
      b1 = (i + 1 < line_fill) ? line_bytes[i + 1] : 8'd0;
      b2 = (i + 2 < line_fill) ? line_bytes[i + 2] : 8'd0;
      push_char(printable(b0[7:2]), 1'b0);
      push_char(printable({b0[1:0], b1[7:4]}), 1'b0);
      push_char(printable({b1[3:0], b2[7:6]}), 1'b0);
      push_char(printable(b2[5:0]), 1'b0);
    end
    push_char(CH_NL, 1'b0);
    line_fill = 0;
  endfunction

  function automatic void encode_word(input logic [7:0] data, input logic present,
                                      input logic eom);
    int n;
    n = expected_chars.size();
    if (present) begin
      if (line_fill < LINE_BYTES) begin
        line_bytes[line_fill] = data;
        line_fill++;
      end
      if (line_fill >= LINE_BYTES) begin
        flush_line();
      end
    end
    if (eom) begin
      if (line_fill > 0) begin
        flush_line();
      end
      push_char(CH_ZERO, 1'b0);
      push_char(CH_NL, 1'b1);
    end
    if (expected_chars.size() > n) begin
      expected_chars[$].last = 1'b1;
    end
  endfunction

  task automatic report_mismatch(input string what, input int want, input int got);
    $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $realtime);
    error_count++;
  endtask

  task automatic send_word(input logic [7:0] data, input logic present, input logic eom);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid          = 1'b1;
    in_ch.data_byte      = data;
    in_ch.byte_present   = present;
    in_ch.end_of_message = eom;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    encode_word(data, present, eom);
  endtask

  // receiver side
  always @(negedge clk) begin
    out_ch.ready = ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    uu_char_t want;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_chars.size() == 0) begin
        report_mismatch("unexpected char", -1, out_ch.out_char);
      end else begin
        want = expected_chars.pop_front();
        if (out_ch.out_char !== want.ch) begin
          report_mismatch("out_char", want.ch, out_ch.out_char);
        end
        if (out_ch.run_last !== want.last) begin
          report_mismatch("run_last", want.last, out_ch.run_last);
        end
        if (out_ch.message_done !== want.done) begin
          report_mismatch("message_done", want.done, out_ch.message_done);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout with %0d chars pending", expected_chars.size());
      $display("** uuencode_line_encoder_core: FAILED **");
      $finish;
    end
  end

  task automatic test_empty_message();
    send_word(8'hA5, 1'b0, 1'b1);
  endtask

  task automatic test_ignored_word();
    send_word(8'h5A, 1'b0, 1'b0);
    send_word(8'hC3, 1'b0, 1'b0);
  endtask

  // one, two, three and four byte lines, extreme bit patterns
  task automatic test_short_groups();
    send_word(8'hFF, 1'b1, 1'b1);
    send_word(8'h00, 1'b1, 1'b0);
    send_word(8'h00, 1'b1, 1'b0);
    send_word(8'h3C, 1'b0, 1'b1);
    send_word(8'hFF, 1'b1, 1'b0);
    send_word(8'h80, 1'b1, 1'b0);
    send_word(8'h01, 1'b1, 1'b1);
    send_word(8'h3F, 1'b1, 1'b0);
    send_word(8'hC0, 1'b1, 1'b0);
    send_word(8'hFC, 1'b1, 1'b0);
    send_word(8'h03, 1'b1, 1'b0);
    send_word(8'h00, 1'b0, 1'b1);
  endtask

  task automatic test_random_traffic(input int unsigned send_pct, input int unsigned stall_pct,
                                     input logic lead_full_line);
    int unsigned sent;
    int unsigned len;
    int unsigned kind;
    int unsigned i;
    logic        end_on_byte;
    logic        first;
    sender_idle_pct = send_pct;
    sink_stall_pct  = stall_pct;
    sent  = 0;
    first = lead_full_line;
    while (sent < PHASE_WORDS) begin
      kind = $urandom_range(9);
      if (first) begin
        len         = LINE_BYTES;
        end_on_byte = 1'b1;
        first       = 1'b0;
      end else begin
        if (kind == 9) begin
          len = LINE_BYTES;
        end else if (kind == 8) begin
          len = $urandom_range(LINE_BYTES + 5, LINE_BYTES - 1);
        end else begin
          len = $urandom_range(8, 0);
        end
        end_on_byte = (len > 0) && ($urandom_range(1) == 1);
      end
      for (i = 0; i < len; i++) begin
        if ($urandom_range(9) == 0) begin
          send_word(8'($urandom_range(255)), 1'b0, 1'b0);
          sent++;
        end
        send_word(8'($urandom_range(255)), 1'b1, end_on_byte && (i == len - 1));
        sent++;
      end
      if (!end_on_byte) begin
        send_word(8'($urandom_range(255)), 1'b0, 1'b1);
        sent++;
      end
    end
  endtask

  initial begin
    rst                  = 1'b1;
    in_ch.valid          = 1'b0;
    in_ch.data_byte      = 8'd0;
    in_ch.byte_present   = 1'b0;
    in_ch.end_of_message = 1'b0;
    out_ch.ready         = 1'b0;
    sender_idle_pct      = 0;
    sink_stall_pct       = 0;
    line_fill            = 0;
    error_count          = 0;
    cycle_count          = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_message();
    test_ignored_word();
    test_short_groups();
    test_random_traffic(0, 0, 1'b1);
    test_random_traffic(59, 0, 1'b0);
    test_random_traffic(0, 59, 1'b0);
    test_random_traffic(13, 13, 1'b1);

    @(negedge clk);
    in_ch.valid = 1'b0;
    while (expected_chars.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_chars.size() != 0) begin
      report_mismatch("chars never sent", 0, expected_chars.size());
    end
    if (error_count == 0) begin
      $display("** uuencode_line_encoder_core: PASSED **");
    end else begin
      $display("** uuencode_line_encoder_core: FAILED **");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hdl
hdl/uuenc_pkg.sv
hdl/uuenc_if.sv
hdl/uuenc_line_mem.sv
hdl/uuenc_char_unit.sv
hdl/uuenc_seq.sv
hdl/uuencode_line_encoder_core.sv
hdl/uuenc_checker.sv
dv/tb_uuencode_line_encoder_core.sv
